[hdl/ffc_pkg.sv]
// shared constants and types for the float / fixed converter
`default_nettype none
package ffc_pkg;
  localparam int unsigned ExpBias = 127;
  localparam int unsigned ManBits = 23;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WORD_BITS = 1'b0,
    REG_FRAC_BITS = 1'b1
  } reg_idx_e;

  // conversion direction
  typedef enum logic [0:0] {
    FUNC_FLT2FIX = 1'b0,
    FUNC_FIX2FLT = 1'b1
  } func_e;

  // conversion settings handed to the datapath
  typedef struct packed {
    logic [5:0] word_bits;
    logic [4:0] frac_bits;
  } cfg_t;
endpackage
`default_nettype wire

[hdl/ffc_flt2fix.sv]
// float to fixed-point conversion datapath
`default_nettype none
module ffc_flt2fix import ffc_pkg::*; (
  input  wire cfg_t        cfg_i,
  input  wire logic [31:0] flt_i,
  output logic      [31:0] fix_o,
  output logic             err_o
);
  logic        neg;
  logic [7:0]  e;
  logic [22:0] m;
  logic [23:0] s;
  logic signed [10:0] k;
  logic [7:0]  sh;
  logic [63:0] mag;
  logic        frac;
  logic [32:0] lim;
  logic [31:0] wmask;
  logic [31:0] negmag;

  always_comb begin
    neg = flt_i[31];
    e = flt_i[30:23];
    m = flt_i[22:0];
    fix_o = '0;
    err_o = 1'b0;
    mag = '0;
    frac = 1'b0;
    sh = '0;
    // significand and scale exponent
    if (e == 8'd0) begin
      s = {1'b0, m};
      k = 11'sd0 - 11'sd149 + $signed({6'd0, cfg_i.frac_bits});
    end else begin
      s = {1'b1, m};
      k = $signed({3'd0, e}) - 11'sd150 + $signed({6'd0, cfg_i.frac_bits});
    end
    // align magnitude
    if (k >= 0) begin
      mag = {40'd0, s} << k[5:0];
    end else begin
      sh = 8'(-k);
      if (sh >= 8'd32) begin
        frac = (s != '0);
      end else begin
        mag = {40'd0, s} >> sh[4:0];
        frac = (({40'd0, s} & ((64'd1 << sh[4:0]) - 64'd1)) != 64'd0);
      end
    end
    lim = 33'd1 << (cfg_i.word_bits - 6'd1);
    if (!neg) lim = lim - 33'd1;
    wmask = 32'hFFFF_FFFF >> (6'd32 - cfg_i.word_bits);
    negmag = (32'd0 - mag[31:0]) & wmask;
    // classify
    if (e == 8'hFF) begin
      err_o = 1'b1;
    end else if (e == 8'd0 && m == '0) begin
      err_o = 1'b0;
    end else if (k > 11'sd40) begin
      err_o = 1'b1;
    end else if (mag > {31'd0, lim} || (mag == {31'd0, lim} && frac)) begin
      err_o = 1'b1;
    end else begin
      fix_o = neg ? negmag : mag[31:0];
    end
  end
endmodule
`default_nettype wire

[hdl/ffc_fix2flt.sv]
// fixed-point to float conversion datapath
`default_nettype none
module ffc_fix2flt import ffc_pkg::*; (
  input  wire cfg_t        cfg_i,
  input  wire logic [31:0] fix_i,
  output logic      [31:0] flt_o
);
  logic [31:0] wmask;
  logic [31:0] x;
  logic        sign;
  logic [31:0] mag;
  logic [4:0]  lead;
  logic [7:0]  ex;
  logic [31:0] man;

  always_comb begin
    wmask = 32'hFFFF_FFFF >> (6'd32 - cfg_i.word_bits);
    x = fix_i & wmask;
    sign = x[5'(cfg_i.word_bits - 6'd1)];
    mag = sign ? ((32'd0 - x) & wmask) : x;
    // leading one search
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lead = 5'(i);
    end
    ex = 8'(ExpBias) + {3'd0, lead} - {3'd0, cfg_i.frac_bits};
    if (lead <= 5'(ManBits)) man = mag << (5'(ManBits) - lead);
    else man = mag >> (lead - 5'(ManBits));
    if (x == '0) flt_o = '0;
    else flt_o = {sign, ex, man[22:0]};
  end
endmodule
`default_nettype wire

[hdl/float_fixed_converter.sv]
// float / fixed-point converter top level
// Usage:
//   Input channel (in_valid_i/in_stall_o) carries func_i and operand_i; a word
//   is accepted on a clock edge with valid high and stall low.
//   Output channel (out_valid_o/out_stall_i) carries converted_o and
//   range_error_o, one result word per input word, in order.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 word_bits,
//   1 fraction_bits) and cfg_data_i; write only while idle.
// Result: out_valid_o goes high in the cycle after acceptance; the conversion is a
//   single combinational pass into the result register.
// Throughput: one word per cycle; the input is stalled only while a result
//   waits in the output register and the receiver stalls it.
// Reset: output empty, word_bits 16, fraction_bits 10.
// A stalled result holds unchanged until taken.
`default_nettype none
module float_fixed_converter import ffc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [31:0] operand_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] converted_o,
  output logic             range_error_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  cfg_t        cfg_q;
  logic        valid_q;
  logic [31:0] res_q;
  logic        err_q;
  logic [31:0] fix_res;
  logic        fix_err;
  logic [31:0] flt_res;
  logic        cfg_ok;
  logic        take;
  logic [31:0] res_d;
  logic        err_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = valid_q && out_stall_i;
  assign take = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.word_bits <= 6'd16;
      cfg_q.frac_bits <= 5'd10;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_WORD_BITS) cfg_q.word_bits <= cfg_data_i[5:0];
      else cfg_q.frac_bits <= cfg_data_i[4:0];
    end
  end

  assign cfg_ok = cfg_q.word_bits >= 6'd2 && cfg_q.word_bits <= 6'd32 &&
                  {1'b0, cfg_q.frac_bits} < cfg_q.word_bits;

  ffc_flt2fix u_flt2fix (.cfg_i(cfg_q), .flt_i(operand_i), .fix_o(fix_res), .err_o(fix_err));
  ffc_fix2flt u_fix2flt (.cfg_i(cfg_q), .fix_i(operand_i), .flt_o(flt_res));

  // result select
  always_comb begin
    if (!cfg_ok) begin
      res_d = '0;
      err_d = 1'b1;
    end else if (func_i == FUNC_FLT2FIX) begin
      res_d = fix_res;
      err_d = fix_err;
    end else begin
      res_d = flt_res;
      err_d = 1'b0;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (!in_stall_o) valid_q <= in_valid_i;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o = valid_q;
  assign converted_o = res_q;
  assign range_error_o = err_q;

  // an error result carries a zero word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> converted_o == '0)
    else $error("error result with nonzero word");

  // accepted word shows up next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("result missing after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(converted_o))
    else $error("stalled result changed");
endmodule
`default_nettype wire
